>>> rtl/endpoint_registry_with_aging_top_macros.svh
// Assertion macros used by the endpoint registry controller.
`ifndef ENDPOINT_REGISTRY_WITH_AGING_TOP_MACROS_SVH
`define ENDPOINT_REGISTRY_WITH_AGING_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ERA_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ERA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> rtl/era_pkg.sv
// Package with types, constants and codes of the endpoint registry.
`default_nettype none
package era_pkg;
	localparam int unsigned TableEntries = 64;
	localparam int unsigned SlotW = $clog2(TableEntries);
	localparam int unsigned CntW = $clog2(TableEntries + 1);

	localparam logic [1:0] CmdTick = 2'd0;
	localparam logic [1:0] CmdReg  = 2'd1;
	localparam logic [1:0] CmdGet  = 2'd2;
	localparam logic [1:0] CmdList = 2'd3;

	localparam logic [2:0] KindAssigned = 3'd0;
	localparam logic [2:0] KindDrop     = 3'd1;
	localparam logic [2:0] KindPoint    = 3'd2;
	localparam logic [2:0] KindList     = 3'd3;
	localparam logic [2:0] KindFull     = 3'd4;

	localparam logic [0:0] RegExpire   = 1'd0;
	localparam logic [0:0] RegReserved = 1'd1;

	localparam logic [30:0] ExpireReset   = 31'd600;
	localparam logic [15:0] ReservedReset = 16'd1024;
	localparam logic [31:0] FirstFreeId   = 32'd1025;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] src_ip;
		logic [15:0] src_port;
		logic [31:0] cluster_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] entry_id;
		logic [31:0] entry_ip;
		logic [15:0] entry_port;
		logic        last;
	} out_item_t;

	// One table entry as held in the slot memory.
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] stamp;
	} slot_t;

	// Memory access request from the controller.
	typedef struct packed {
		logic             rd_en;
		logic [SlotW-1:0] rd_addr;
		logic             wr_en;
		logic [SlotW-1:0] wr_addr;
		slot_t            wr_data;
	} mem_req_t;
endpackage
`default_nettype wire

>>> rtl/era_slot_mem.sv
// Slot memory: one synchronous write port, one registered read port.
`default_nettype none
module era_slot_mem (
	input  wire logic           clk,
	input  wire era_pkg::mem_req_t req,
	output era_pkg::slot_t      rd_data
);
	import era_pkg::*;

	slot_t mem [TableEntries];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/era_ctrl.sv
// Sequencer that scans the slot memory for register, get and list items and builds their results.
`default_nettype none
module era_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire era_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output era_pkg::out_item_t     out_item,
	input  wire logic [30:0]       expire_ticks,
	input  wire logic [15:0]       reserved_id_limit,
	output era_pkg::mem_req_t      mreq,
	input  wire era_pkg::slot_t    rdata,
	output logic                   idle
);
	import era_pkg::*;
	`include "endpoint_registry_with_aging_top_macros.svh"

	typedef enum logic [4:0] {
		StIdle  = 5'b00001,
		StScan  = 5'b00010,
		StAct   = 5'b00100,
		StList  = 5'b01000,
		StEmit  = 5'b10000
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [TableEntries-1:0] valid_q;
	logic [31:0] next_id_q, now_q;
	logic [CntW-1:0] cnt_q;       // address issued
	logic [CntW-1:0] cnt_s1;      // slot whose data is on rdata
	logic rd_s1;
	logic own_f_q, idm_f_q;
	logic [SlotW-1:0] own_q, idm_q;
	logic [31:0] own_id_q;
	slot_t idm_data_q;
	logic lst_pend_q;
	out_item_t lst_q;
	logic ov_q;
	out_item_t ob_q;

	logic free_f;
	logic [SlotW-1:0] free_s;
	logic [31:0] age;
	logic stale;
	logic idm_stale;
	logic [SlotW-1:0] cur;
	logic ob_free;
	logic drop_own;
	logic [TableEntries-1:0] valid_eff;
	logic [TableEntries-1:0] valid_act;
	out_item_t act_res;
	logic act_reply;
	logic act_alloc;
	logic lst_hit;
	logic lst_done;
	logic ov_set;

	assign cur = cnt_s1[SlotW-1:0];
	assign age = now_q - rdata.stamp;
	assign stale = age > {1'b0, expire_ticks};
	assign idm_stale = (now_q - idm_data_q.stamp) > {1'b0, expire_ticks};
	assign ob_free = !ov_q || !out_stall;
	assign out_valid = ov_q;
	assign out_item = ob_q;
	assign in_stall = (state_q != StIdle) || ov_q;
	assign idle = (state_q == StIdle) && !ov_q;
	assign lst_hit = rd_s1 && valid_q[cur] && !stale;
	assign lst_done = !mreq.rd_en && !rd_s1;
	assign ov_set = ((state_q == StEmit) && !ov_q)
		|| ((state_q == StList) && ob_free && lst_pend_q && (lst_hit || lst_done));

	// A register item with a new ID first frees the sender's old entry.
	assign drop_own = (item_q.command == CmdReg) && (item_q.cluster_id != 32'd0)
		&& own_f_q && (own_id_q != item_q.cluster_id);

	// Valid bits as seen after the sender's old entry is freed.
	always_comb begin
		valid_eff = valid_q;
		if (drop_own) begin
			valid_eff[own_q] = 1'b0;
		end
	end

	// Lowest free slot from the valid bits.
	always_comb begin
		free_f = 1'b0;
		free_s = '0;
		for (int i = TableEntries - 1; i >= 0; i--) begin
			if (!valid_eff[i]) begin
				free_f = 1'b1;
				free_s = SlotW'(i);
			end
		end
	end

	// Memory request: scan reads during StScan/StList, writes in StAct.
	always_comb begin
		mreq = '0;
		mreq.rd_en = ((state_q == StScan) || (state_q == StList && ob_free))
			&& (cnt_q < CntW'(TableEntries));
		mreq.rd_addr = cnt_q[SlotW-1:0];
		if (state_q == StAct && item_q.command == CmdReg) begin
			mreq.wr_data.ip = item_q.src_ip;
			mreq.wr_data.port = item_q.src_port;
			mreq.wr_data.stamp = now_q;
			if (item_q.cluster_id != 32'd0) begin
				mreq.wr_data.id = item_q.cluster_id;
				mreq.wr_addr = idm_f_q ? idm_q : free_s;
				mreq.wr_en = idm_f_q || free_f;
			end else if (own_f_q) begin
				mreq.wr_data.id = own_id_q;
				mreq.wr_addr = own_q;
				mreq.wr_en = 1'b1;
			end else begin
				mreq.wr_data.id = next_id_q;
				mreq.wr_addr = free_s;
				mreq.wr_en = free_f;
			end
		end
	end

	// Decision after a register or get scan: result, valid bits and allocation.
	always_comb begin
		act_res = '0;
		act_res.last = 1'b1;
		act_res.entry_id = item_q.cluster_id;
		act_reply = 1'b1;
		act_alloc = 1'b0;
		valid_act = valid_eff;
		if (item_q.command == CmdReg) begin
			if (item_q.cluster_id != 32'd0) begin
				if (idm_f_q) begin
					valid_act[idm_q] = 1'b1;
					act_reply = 1'b0;
				end else if (free_f) begin
					valid_act[free_s] = 1'b1;
					act_reply = 1'b0;
				end else begin
					act_res.kind = KindFull;
				end
			end else if (own_f_q) begin
				act_res.kind = KindAssigned;
				act_res.entry_id = own_id_q;
			end else if (free_f) begin
				valid_act[free_s] = 1'b1;
				act_res.kind = KindAssigned;
				act_res.entry_id = next_id_q;
				act_alloc = 1'b1;
			end else begin
				act_res.kind = KindFull;
				act_res.entry_id = next_id_q;
			end
		end else if (!idm_f_q) begin
			act_res.kind = KindDrop;
		end else if (idm_stale) begin
			if (item_q.cluster_id > {16'd0, reserved_id_limit}) begin
				valid_act[idm_q] = 1'b0;
				act_res.kind = KindDrop;
			end else begin
				act_reply = 1'b0;
			end
		end else begin
			act_res.kind = KindPoint;
			act_res.entry_ip = idm_data_q.ip;
			act_res.entry_port = idm_data_q.port;
		end
	end

	// Output register: loaded when a result is ready, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ov_set) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			valid_q <= '0;
			next_id_q <= FirstFreeId;
			now_q <= '0;
			cnt_q <= '0;
			cnt_s1 <= '0;
			rd_s1 <= 1'b0;
			own_f_q <= 1'b0;
			idm_f_q <= 1'b0;
			lst_pend_q <= 1'b0;
		end else begin
			// The read pipeline holds while a list result waits.
			if (state_q != StList || ob_free) begin
				rd_s1 <= mreq.rd_en;
				cnt_s1 <= cnt_q;
			end
			unique case (state_q)
				StIdle: begin
					if (in_valid && !in_stall) begin
						item_q <= in_item;
						cnt_q <= '0;
						own_f_q <= 1'b0;
						idm_f_q <= 1'b0;
						lst_pend_q <= 1'b0;
						unique case (in_item.command)
							CmdTick: now_q <= now_q + 32'd1;
							CmdList: state_q <= StList;
							default: state_q <= StScan;
						endcase
					end
				end
				StScan: begin
					if (mreq.rd_en) begin
						cnt_q <= cnt_q + CntW'(1);
					end
					if (rd_s1 && valid_q[cur]) begin
						if (!own_f_q && rdata.ip == item_q.src_ip
								&& rdata.port == item_q.src_port) begin
							own_f_q <= 1'b1;
							own_q <= cur;
							own_id_q <= rdata.id;
						end
						if (!idm_f_q && rdata.id == item_q.cluster_id) begin
							idm_f_q <= 1'b1;
							idm_q <= cur;
							idm_data_q <= rdata;
						end
					end
					if (!mreq.rd_en && !rd_s1) begin
						// All slots seen; decide in the next cycle.
						state_q <= StAct;
					end
				end
				StAct: begin
					ob_q <= act_res;
					valid_q <= valid_act;
					if (act_alloc) begin
						next_id_q <= (next_id_q == 32'hFFFF_FFFF) ? 32'd1
							: next_id_q + 32'd1;
					end
					state_q <= act_reply ? StEmit : StIdle;
				end
				StEmit: begin
					if (!ov_q) begin
						state_q <= StIdle;
					end
				end
				StList: begin
					// One slot a cycle while the output register is free; a found entry waits in lst_q until
					// the next found entry or the end of the scan shows whether it is the last.
					if (ob_free) begin
						if (mreq.rd_en) begin
							cnt_q <= cnt_q + CntW'(1);
						end
						if (lst_hit) begin
							if (lst_pend_q) begin
								ob_q <= lst_q;
							end
							lst_pend_q <= 1'b1;
							lst_q <= '{kind: KindList, entry_id: rdata.id,
								entry_ip: 32'd0, entry_port: 16'd0, last: 1'b0};
						end else if (lst_done) begin
							if (lst_pend_q) begin
								ob_q <= '{kind: KindList, entry_id: lst_q.entry_id,
									entry_ip: 32'd0, entry_port: 16'd0, last: 1'b1};
							end
							state_q <= StIdle;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`ERA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != StIdle, in_stall,
		"item accepted while busy")
	`ERA_ASSERT_NEXT(a_out_hold, clk, arst_n, ov_q && out_stall, ov_q && $stable(ob_q),
		"stalled result changed")
	`ERA_ASSERT_IMP(a_no_rw_clash, clk, arst_n, mreq.wr_en, !mreq.rd_en,
		"memory read and write in same cycle")
endmodule
`default_nettype wire

>>> rtl/endpoint_registry_with_aging_top.sv
// Top level of the endpoint registry with aging.
//
// Usage: items enter on in_valid/in_stall with fields in in_item; results
// leave on out_valid/out_stall in out_item, last marking an item's final one.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is high only while the block is idle.
// Operation: a tick is handled in the idle state. A register or get item scans
// all 64 slots of the slot memory, one read per cycle, and then presents its
// result; the next item is taken once any result has left. A list item scans
// the same way, but its reads pause while a result waits; each fresh entry
// leaves once the next one is found, and the final result once the scan ends.
// The registered read of the slot memory and the scan of one slot per cycle
// set the pace. One item is worked on at a time; in_stall is high while busy
// or while a result waits.
// Reset clears all valid bits, sets the next free ID to 1025, time to zero
// and the registers to 600 and 1024; no clearing pass is needed.
// When the receiver stalls, the result holds steady and the scan pauses.
`default_nettype none
module endpoint_registry_with_aging_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire era_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output era_pkg::out_item_t     out_item,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);
	import era_pkg::*;

	logic [30:0] expire_q;
	logic [15:0] reserved_q;
	mem_req_t mreq;
	slot_t rdata;
	logic idle;

	assign cfg_ready = idle;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expire_q <= ExpireReset;
			reserved_q <= ReservedReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegExpire:   expire_q <= cfg_data[30:0];
				RegReserved: reserved_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	era_slot_mem u_mem (.clk(clk), .req(mreq), .rd_data(rdata));

	era_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.expire_ticks(expire_q), .reserved_id_limit(reserved_q),
		.mreq(mreq), .rdata(rdata), .idle(idle)
	);
endmodule
`default_nettype wire

>>> test/tb_endpoint_registry_with_aging_top.sv
// Testbench for the endpoint registry: random and directed items checked against a predictor.
`default_nettype none
module tb_endpoint_registry_with_aging_top;
	import era_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSlots = 64;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;

	endpoint_registry_with_aging_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predicted table contents and settings.
	logic        tbl_valid [NSlots];
	logic [31:0] tbl_id    [NSlots];
	logic [31:0] tbl_ip    [NSlots];
	logic [15:0] tbl_port  [NSlots];
	logic [31:0] tbl_stamp [NSlots];
	logic [31:0] alloc_id;
	logic [31:0] now_ticks;
	logic [30:0] expire_set;
	logic [15:0] reserved_set;

	out_item_t replies_due[$];
	int        error_count;
	int        hold_cycles;

	// Small pools of addresses and IDs so that lookups hit often.
	logic [31:0] ip_pool  [4] = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0101};
	logic [15:0] port_pool[3] = '{16'h0, 16'hFFFF, 16'd5000};
	logic [31:0] id_pool  [6] = '{32'd1, 32'd1024, 32'd1025, 32'd2000, 32'hFFFF_FFFF, 32'd7};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_endpoint_registry_with_aging_top: errors");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic logic entry_stale(input int s);
		logic [31:0] age;
		age = now_ticks - tbl_stamp[s];
		return age > {1'b0, expire_set};
	endfunction

	function automatic int slot_of_addr(input logic [31:0] ip, input logic [15:0] port);
		for (int s = 0; s < NSlots; s++)
			if (tbl_valid[s] && tbl_ip[s] == ip && tbl_port[s] == port)
				return s;
		return -1;
	endfunction

	function automatic int slot_of_id(input logic [31:0] id);
		for (int s = 0; s < NSlots; s++)
			if (tbl_valid[s] && tbl_id[s] == id)
				return s;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int s = 0; s < NSlots; s++)
			if (!tbl_valid[s])
				return s;
		return -1;
	endfunction

	function automatic void queue_reply(input logic [2:0] kind, input logic [31:0] id,
			input logic [31:0] ip, input logic [15:0] port);
		out_item_t r;
		r.kind = kind;
		r.entry_id = id;
		r.entry_ip = ip;
		r.entry_port = port;
		r.last = 1'b0;
		replies_due.push_back(r);
	endfunction

	function automatic void fill_slot(input int s, input logic [31:0] id,
			input logic [31:0] ip, input logic [15:0] port);
		tbl_valid[s] = 1'b1;
		tbl_id[s] = id;
		tbl_ip[s] = ip;
		tbl_port[s] = port;
		tbl_stamp[s] = now_ticks;
	endfunction

	// Apply one item to the predicted table and queue the replies it causes.
	function automatic void registry_update(input in_item_t it);
		int own;
		int s;
		int before_cnt;
		before_cnt = replies_due.size();
		case (it.command)
			CmdTick: now_ticks = now_ticks + 1;
			CmdReg: begin
				own = slot_of_addr(it.src_ip, it.src_port);
				if (it.cluster_id != 0) begin
					if (own >= 0 && tbl_id[own] != it.cluster_id)
						tbl_valid[own] = 1'b0;
					s = slot_of_id(it.cluster_id);
					if (s < 0)
						s = free_slot();
					if (s < 0)
						queue_reply(KindFull, it.cluster_id, 0, 0);
					else
						fill_slot(s, it.cluster_id, it.src_ip, it.src_port);
				end else if (own >= 0) begin
					tbl_stamp[own] = now_ticks;
					queue_reply(KindAssigned, tbl_id[own], 0, 0);
				end else begin
					s = free_slot();
					if (s < 0) begin
						queue_reply(KindFull, alloc_id, 0, 0);
					end else begin
						fill_slot(s, alloc_id, it.src_ip, it.src_port);
						queue_reply(KindAssigned, alloc_id, 0, 0);
						alloc_id = alloc_id + 1;
						if (alloc_id == 0)
							alloc_id = 1;
					end
				end
			end
			CmdGet: begin
				s = slot_of_id(it.cluster_id);
				if (s < 0) begin
					queue_reply(KindDrop, it.cluster_id, 0, 0);
				end else if (entry_stale(s)) begin
					if (it.cluster_id > {16'd0, reserved_set}) begin
						tbl_valid[s] = 1'b0;
						queue_reply(KindDrop, it.cluster_id, 0, 0);
					end
				end else begin
					queue_reply(KindPoint, it.cluster_id, tbl_ip[s], tbl_port[s]);
				end
			end
			default: begin
				for (int k = 0; k < NSlots; k++)
					if (tbl_valid[k] && !entry_stale(k))
						queue_reply(KindList, tbl_id[k], 0, 0);
			end
		endcase
		if (replies_due.size() > before_cnt)
			replies_due[replies_due.size() - 1].last = 1'b1;
	endfunction

	// Send one item after a random gap; predict at acceptance. Valid stays up
	// after acceptance until the next item or an idle wait takes it down.
	task automatic send_item(input in_item_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		registry_update(it);
		@(negedge clk);
	endtask

	function automatic in_item_t make_item(input logic [1:0] cmd, input logic [31:0] ip,
			input logic [15:0] port, input logic [31:0] id);
		in_item_t it;
		it.command = cmd;
		it.src_ip = ip;
		it.src_port = port;
		it.cluster_id = id;
		return it;
	endfunction

	// Random item, mostly from small pools, sometimes fully random fields.
	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) it.command = CmdTick;
		else if (pick < 55) it.command = CmdReg;
		else if (pick < 85) it.command = CmdGet;
		else it.command = CmdList;
		if ($urandom_range(0, 4) == 0) begin
			it.src_ip = $urandom;
			it.src_port = 16'($urandom);
		end else begin
			it.src_ip = ip_pool[$urandom_range(0, 3)];
			it.src_port = port_pool[$urandom_range(0, 2)];
		end
		pick = $urandom_range(0, 9);
		if (pick < 3) it.cluster_id = 0;
		else if (pick < 8) it.cluster_id = id_pool[$urandom_range(0, 5)];
		else it.cluster_id = $urandom;
		return it;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == RegExpire)
			expire_set = val[30:0];
		else
			reserved_set = val[15:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker with random receiver stalls and an optional long hold.
	initial begin
		int wait_n;
		out_item_t exp_r;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("unexpected reply kind %0d id %0h",
					out_item.kind, out_item.entry_id));
			end else begin
				exp_r = replies_due.pop_front();
				if (out_item.kind !== exp_r.kind)
					report_mismatch($sformatf("kind %0d, want %0d", out_item.kind, exp_r.kind));
				if (out_item.entry_id !== exp_r.entry_id)
					report_mismatch($sformatf("entry_id %0h, want %0h",
						out_item.entry_id, exp_r.entry_id));
				if (out_item.entry_ip !== exp_r.entry_ip)
					report_mismatch($sformatf("entry_ip %0h, want %0h",
						out_item.entry_ip, exp_r.entry_ip));
				if (out_item.entry_port !== exp_r.entry_port)
					report_mismatch($sformatf("entry_port %0h, want %0h",
						out_item.entry_port, exp_r.entry_port));
				if (out_item.last !== exp_r.last)
					report_mismatch($sformatf("last %0b, want %0b", out_item.last, exp_r.last));
			end
		end
	end

	// Extremes of every field, each command, allocation, rename and lookups.
	task automatic test_directed();
		send_item(make_item(CmdList, 0, 0, 0));
		send_item(make_item(CmdGet, 0, 0, 0));
		send_item(make_item(CmdReg, 32'hFFFF_FFFF, 16'hFFFF, 0));
		send_item(make_item(CmdReg, 32'hFFFF_FFFF, 16'hFFFF, 0));
		send_item(make_item(CmdReg, 0, 0, 32'hFFFF_FFFF));
		send_item(make_item(CmdGet, 0, 0, 32'hFFFF_FFFF));
		send_item(make_item(CmdReg, 0, 0, 32'd5));
		send_item(make_item(CmdGet, 0, 0, 32'hFFFF_FFFF));
		send_item(make_item(CmdGet, 32'hFFFF_FFFF, 16'hFFFF, 32'd1025));
		send_item(make_item(CmdReg, 32'h1234_5678, 16'h8001, 32'd1025));
		send_item(make_item(CmdList, 0, 0, 0));
		send_item(make_item(CmdTick, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
		send_item(make_item(CmdGet, 0, 0, 32'd5));
	endtask

	// Short expiry: stale entries above and at the reserved limit.
	task automatic test_aging();
		wait_drained();
		write_reg(RegExpire, 32'd1);
		write_reg(RegReserved, 32'd5);
		send_item(make_item(CmdReg, 32'd77, 16'd77, 32'd3000));
		repeat (3) send_item(make_item(CmdTick, 0, 0, 0));
		send_item(make_item(CmdList, 0, 0, 0));
		send_item(make_item(CmdGet, 0, 0, 32'd5));
		send_item(make_item(CmdGet, 0, 0, 32'd3000));
		send_item(make_item(CmdGet, 0, 0, 32'd3000));
		wait_drained();
		write_reg(RegExpire, 32'hFFFF_FFFF);
		write_reg(RegReserved, 32'hFFFF);
	endtask

	// Fill the table until it reports full, then age every entry out.
	task automatic test_full_table();
		for (int i = 0; i < 66; i++)
			send_item(make_item(CmdReg, 32'hA000_0000 + i, i[15:0], 0));
		send_item(make_item(CmdReg, 32'hB000_0000, 16'd1, 32'd9999));
		send_item(make_item(CmdList, 0, 0, 0));
		wait_drained();
		write_reg(RegExpire, 32'd0);
		write_reg(RegReserved, 32'd0);
		send_item(make_item(CmdTick, 0, 0, 0));
		for (int i = 0; i < 66; i++)
			send_item(make_item(CmdGet, 0, 0, tbl_id[i % NSlots]));
	endtask

	// Receiver holds off while items keep coming.
	task automatic test_backpressure();
		wait_drained();
		write_reg(RegExpire, 32'd600);
		write_reg(RegReserved, 32'd1024);
		hold_cycles = 400;
		repeat (4) send_item(make_item(CmdList, 0, 0, 0));
		for (int i = 0; i < 6; i++)
			send_item(make_item(CmdReg, $urandom, 16'($urandom), 0));
	endtask

	// Random traffic over several settings.
	task automatic test_random();
		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			write_reg(RegExpire, (phase == 0) ? 32'd3 : $urandom_range(1, 40));
			write_reg(RegReserved, (phase == 1) ? 32'd0 : $urandom_range(0, 3000));
			for (int i = 0; i < 40; i++)
				send_item(random_item());
		end
	endtask

	initial begin
		error_count = 0;
		hold_cycles = 0;
		for (int s = 0; s < NSlots; s++) begin
			tbl_valid[s] = 1'b0;
			tbl_id[s] = '0;
			tbl_ip[s] = '0;
			tbl_port[s] = '0;
			tbl_stamp[s] = '0;
		end
		alloc_id = FirstFreeId;
		now_ticks = '0;
		expire_set = ExpireReset;
		reserved_set = ReservedReset;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_aging();
		test_full_table();
		test_backpressure();
		test_random();
		wait_drained();
		if (error_count == 0)
			$display("tb_endpoint_registry_with_aging_top: clean");
		else
			$display("tb_endpoint_registry_with_aging_top: errors");
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/era_pkg.sv
rtl/era_slot_mem.sv
rtl/era_ctrl.sv
rtl/endpoint_registry_with_aging_top.sv
test/tb_endpoint_registry_with_aging_top.sv
